/* hdl/relay_switch_bank_with_off_delay_top_macros.svh */
// Assertion macros used by the port-level checker of the relay switch bank.
`ifndef RELAY_SWITCH_BANK_WITH_OFF_DELAY_TOP_MACROS_SVH
`define RELAY_SWITCH_BANK_WITH_OFF_DELAY_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RSB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/rsb_pkg.sv */
// Package with types, codes and sizes of the relay switch bank.
`default_nettype none
package rsb_pkg;

    localparam int CHANNELS = 4;
    localparam int PIN_W    = 4;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_RESTORE = 2'd3
    } t_action;

    localparam logic [7:0] ADDR_CONFIG = 8'd0;
    localparam logic [7:0] ADDR_VALUE  = 8'd1;
    localparam logic [7:0] ADDR_DELAY  = 8'd2;

    localparam logic [3:0] LEN_CONFIG = 4'd1;
    localparam logic [3:0] LEN_VALUE  = 4'd1;
    localparam logic [3:0] LEN_DELAY  = 4'd2;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ONE  = 2'd1;
    localparam logic [1:0] REPLY_TWO  = 2'd2;

    localparam int CFG_POLARITY_BIT = 0;
    localparam int CFG_OFFDELAY_BIT = 1;
    localparam int CFG_DEFON_BIT    = 2;
    localparam logic [7:0] CFG_MASK = 8'h07;

    typedef struct packed {
        t_action    action;
        logic [1:0] channel;
        logic [7:0] address;
        logic [3:0] length;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } t_in;

    typedef struct packed {
        logic [1:0]       reply_count;
        logic [7:0]       reply_high;
        logic [7:0]       reply_low;
        logic [PIN_W-1:0] pin_levels;
    } t_out;

    // Per-channel operation strobes from the command decoder.
    typedef struct packed {
        logic wr_config;
        logic wr_value;
        logic wr_delay;
        logic restore;
        logic tick;
    } t_ch_op;

    // Per-channel state seen by the decoder.
    typedef struct packed {
        logic [7:0]  config_byte;
        logic        switch_on;
        logic [15:0] delay_limit;
        logic        pin_next;
    } t_ch_stat;

endpackage
`default_nettype wire

/* hdl/rsb_channel.sv */
// One switch channel: config, mode, off delay and off-delay timer.
`default_nettype none
module rsb_channel (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  rsb_pkg::t_ch_op      i_op,
    input  wire  [7:0]           i_byte0,
    input  wire  [7:0]           i_byte1,
    input  wire  [7:0]           i_byte2,
    output rsb_pkg::t_ch_stat    o_stat
);

    logic [7:0]  r_config, n_config;
    logic        r_on,     n_on;
    logic [15:0] r_limit,  n_limit;
    logic [15:0] r_count,  n_count;
    logic [15:0] count_inc;

    assign count_inc = r_count + 16'd1;

    always_comb begin
        n_config = r_config;
        n_on     = r_on;
        n_limit  = r_limit;
        n_count  = r_count;
        if (i_op.wr_config) begin
            n_config = i_byte0 & rsb_pkg::CFG_MASK;
        end
        if (i_op.wr_value) begin
            n_on    = (i_byte0 != 8'd0);
            n_count = 16'd0;
        end
        if (i_op.wr_delay) begin
            n_limit = {i_byte0, i_byte1};
        end
        if (i_op.restore) begin
            n_config = i_byte0;
            n_limit  = {i_byte1, i_byte2};
            n_count  = 16'd0;
            n_on     = i_byte0[rsb_pkg::CFG_DEFON_BIT];
        end
        // Advance the timer of an enabled channel that is on; drop it at the limit.
        if (i_op.tick && r_on && r_config[rsb_pkg::CFG_OFFDELAY_BIT]) begin
            if (count_inc >= r_limit) begin
                n_on    = 1'b0;
                n_count = 16'd0;
            end else begin
                n_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_config <= 8'd0;
            r_on     <= 1'b0;
            r_limit  <= 16'd0;
            r_count  <= 16'd0;
        end else begin
            r_config <= n_config;
            r_on     <= n_on;
            r_limit  <= n_limit;
            r_count  <= n_count;
        end
    end

    assign o_stat.config_byte = r_config;
    assign o_stat.switch_on   = r_on;
    assign o_stat.delay_limit = r_limit;
    assign o_stat.pin_next    = n_on ^ n_config[rsb_pkg::CFG_POLARITY_BIT];

endmodule
`default_nettype wire

/* hdl/relay_switch_bank_with_off_delay_top.sv */
// Top level of the relay switch bank with off delay.
`default_nettype none
// A bank of output switches behind a tiny register interface. Each transfer on
// the command side (i_start high while o_busy is low) carries one command: a
// register read, a register write, a timer tick for every channel, or a restore
// of saved settings for one channel. Every command gives exactly one result,
// shown on o_result for a single cycle with o_strobe high, after the input and
// result registers. The receiver cannot stall the result, so it must take it
// in that cycle. A new command is taken every cycle while o_busy is low; o_busy
// is low at all times except during reset and until the busy register clears
// after it. The rate, one command per cycle, is set by the state update: one
// register stage latches the command, and the next edge updates all channel
// state and the result register together, so each command sees everything
// earlier commands left behind. Pin levels in a result are those after the
// command took effect; a channel's pin is its on/off mode XOR its polarity bit.
module relay_switch_bank_with_off_delay_top (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    output logic           o_busy,
    input  rsb_pkg::t_in   i_cmd,
    output logic           o_strobe,
    output rsb_pkg::t_out  o_result
);

    logic              r_busy;
    logic              r_in_vld;
    rsb_pkg::t_in      r_in;
    logic              r_out_vld;
    rsb_pkg::t_out     r_out, n_out;
    logic              accept;
    logic              ch_ok;

    rsb_pkg::t_ch_op   ch_op   [rsb_pkg::CHANNELS];
    rsb_pkg::t_ch_stat ch_stat [rsb_pkg::CHANNELS];
    logic [rsb_pkg::PIN_W-1:0] pins_next;

    assign accept = i_start && !r_busy;
    assign ch_ok  = (int'(r_in.channel) < rsb_pkg::CHANNELS);

    // Latch the command on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_in_vld <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_in_vld <= accept;
        end
        if (accept) begin
            r_in <= i_cmd;
        end
    end

    // Decode per-channel operations from the latched command.
    genvar gi;
    generate
        for (gi = 0; gi < rsb_pkg::CHANNELS; gi++) begin : g_ch
            logic sel;
            assign sel = r_in_vld && (int'(r_in.channel) == gi);
            assign ch_op[gi].wr_config = sel && (r_in.action == rsb_pkg::ACT_WRITE)
                && (r_in.address == rsb_pkg::ADDR_CONFIG)
                && (r_in.length == rsb_pkg::LEN_CONFIG);
            assign ch_op[gi].wr_value = sel && (r_in.action == rsb_pkg::ACT_WRITE)
                && (r_in.address == rsb_pkg::ADDR_VALUE)
                && (r_in.length == rsb_pkg::LEN_VALUE);
            assign ch_op[gi].wr_delay = sel && (r_in.action == rsb_pkg::ACT_WRITE)
                && (r_in.address == rsb_pkg::ADDR_DELAY)
                && (r_in.length == rsb_pkg::LEN_DELAY);
            assign ch_op[gi].restore = sel && (r_in.action == rsb_pkg::ACT_RESTORE);
            assign ch_op[gi].tick    = r_in_vld && (r_in.action == rsb_pkg::ACT_TICK);

            rsb_channel u_channel (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (ch_op[gi]),
                .i_byte0 (r_in.byte0),
                .i_byte1 (r_in.byte1),
                .i_byte2 (r_in.byte2),
                .o_stat  (ch_stat[gi])
            );
        end

        // Gather pin levels after the command; pins without a channel read low.
        for (gi = 0; gi < rsb_pkg::PIN_W; gi++) begin : g_pin
            if (gi < rsb_pkg::CHANNELS) begin : g_used
                assign pins_next[gi] = ch_stat[gi].pin_next;
            end else begin : g_unused
                assign pins_next[gi] = 1'b0;
            end
        end
    endgenerate

    // Build the reply from the state before the command, the pin levels from the state after it.
    always_comb begin
        n_out             = '0;
        n_out.pin_levels  = pins_next;
        if (r_in.action == rsb_pkg::ACT_READ && ch_ok) begin
            for (int i = 0; i < rsb_pkg::CHANNELS; i++) begin
                if (int'(r_in.channel) == i) begin
                    case (r_in.address)
                        rsb_pkg::ADDR_CONFIG: begin
                            n_out.reply_count = rsb_pkg::REPLY_ONE;
                            n_out.reply_high  = ch_stat[i].config_byte;
                        end
                        rsb_pkg::ADDR_VALUE: begin
                            n_out.reply_count = rsb_pkg::REPLY_ONE;
                            n_out.reply_high  = {7'd0, ch_stat[i].switch_on};
                        end
                        rsb_pkg::ADDR_DELAY: begin
                            n_out.reply_count = rsb_pkg::REPLY_TWO;
                            n_out.reply_high  = ch_stat[i].delay_limit[15:8];
                            n_out.reply_low   = ch_stat[i].delay_limit[7:0];
                        end
                        default: begin
                            n_out.reply_count = rsb_pkg::REPLY_NONE;
                        end
                    endcase
                end
            end
        end
    end

    // Register the result together with the state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule
`default_nettype wire

/* hdl/rsb_checker.sv */
// Port-level checker for the relay switch bank, bound to the top level.
`default_nettype none
`include "relay_switch_bank_with_off_delay_top_macros.svh"
module rsb_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_start,
    input wire           o_busy,
    input rsb_pkg::t_in  i_cmd,
    input wire           o_strobe,
    input rsb_pkg::t_out o_result
);

    logic xfer;
    assign xfer = i_start && !o_busy;

    // Every transfer gives its result, after the input and result registers.
    `RSB_ASSERT(a_result_follows, xfer |-> ##2 o_strobe, "missing result for transfer")
    // No result appears without an earlier transfer.
    `RSB_ASSERT(a_no_spurious, o_strobe |-> $past(xfer, 2), "result without transfer")
    // A command with no reply carries zero reply bytes.
    `RSB_ASSERT(a_empty_reply, (o_strobe && o_result.reply_count == rsb_pkg::REPLY_NONE)
        |-> (o_result.reply_high == 8'd0 && o_result.reply_low == 8'd0), "stale reply bytes")
    // Only a two-byte reply fills the low byte, and the count never exceeds two.
    `RSB_ASSERT(a_low_byte, o_strobe |-> (o_result.reply_count != 2'd3 &&
        (o_result.reply_count == rsb_pkg::REPLY_TWO || o_result.reply_low == 8'd0)),
        "bad reply count or low byte")
    // Reset holds off transfers.
    `RSB_ASSERT_ALWAYS(a_busy_in_reset, !i_rst_n |=> o_busy, "not busy after reset")

endmodule

bind relay_switch_bank_with_off_delay_top rsb_checker u_rsb_checker (.*);
`default_nettype wire

/* verif/rsb_bank_checker.sv */
// Checker that predicts and compares every result of the relay switch bank.
`timescale 1ns / 1ps
`default_nettype none
module rsb_bank_checker (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire            i_busy,
    input  rsb_pkg::t_in   i_cmd,
    input  wire            i_strobe,
    input  rsb_pkg::t_out  i_result,
    output int             o_fail_count,
    output int             o_pending
);

    // Predicted per-channel state of the bank.
    logic        sw_on     [rsb_pkg::CHANNELS];
    logic [7:0]  cfg_byte  [rsb_pkg::CHANNELS];
    logic [15:0] dly_limit [rsb_pkg::CHANNELS];
    logic [15:0] dly_count [rsb_pkg::CHANNELS];

    rsb_pkg::t_out expected_replies[$];
    int            mismatches = 0;

    // Apply one command to the predicted state and return the reply it gives.
    function automatic rsb_pkg::t_out predict_reply(input rsb_pkg::t_in c);
        rsb_pkg::t_out r;
        int            i;
        r = '0;
        case (c.action)
            rsb_pkg::ACT_READ: begin
                if (c.channel < rsb_pkg::CHANNELS) begin
                    case (c.address)
                        rsb_pkg::ADDR_CONFIG: begin
                            r.reply_count = rsb_pkg::REPLY_ONE;
                            r.reply_high  = cfg_byte[c.channel];
                        end
                        rsb_pkg::ADDR_VALUE: begin
                            r.reply_count = rsb_pkg::REPLY_ONE;
                            r.reply_high  = {7'd0, sw_on[c.channel]};
                        end
                        rsb_pkg::ADDR_DELAY: begin
                            r.reply_count = rsb_pkg::REPLY_TWO;
                            r.reply_high  = dly_limit[c.channel][15:8];
                            r.reply_low   = dly_limit[c.channel][7:0];
                        end
                        default: ;
                    endcase
                end
            end
            rsb_pkg::ACT_WRITE: begin
                if (c.channel < rsb_pkg::CHANNELS) begin
                    if (c.address == rsb_pkg::ADDR_CONFIG
                            && c.length == rsb_pkg::LEN_CONFIG) begin
                        cfg_byte[c.channel] = c.byte0 & rsb_pkg::CFG_MASK;
                    end else if (c.address == rsb_pkg::ADDR_VALUE
                            && c.length == rsb_pkg::LEN_VALUE) begin
                        sw_on[c.channel]     = (c.byte0 != 8'd0);
                        dly_count[c.channel] = '0;
                    end else if (c.address == rsb_pkg::ADDR_DELAY
                            && c.length == rsb_pkg::LEN_DELAY) begin
                        dly_limit[c.channel] = {c.byte0, c.byte1};
                    end
                end
            end
            rsb_pkg::ACT_TICK: begin
                for (i = 0; i < rsb_pkg::CHANNELS; i++) begin
                    if (sw_on[i] && cfg_byte[i][rsb_pkg::CFG_OFFDELAY_BIT]) begin
                        dly_count[i] = dly_count[i] + 16'd1;
                        if (dly_count[i] >= dly_limit[i]) begin
                            sw_on[i]     = 1'b0;
                            dly_count[i] = '0;
                        end
                    end
                end
            end
            rsb_pkg::ACT_RESTORE: begin
                if (c.channel < rsb_pkg::CHANNELS) begin
                    cfg_byte[c.channel]  = c.byte0;
                    dly_limit[c.channel] = {c.byte1, c.byte2};
                    dly_count[c.channel] = '0;
                    sw_on[c.channel]     = c.byte0[rsb_pkg::CFG_DEFON_BIT];
                end
            end
            default: ;
        endcase
        for (i = 0; i < rsb_pkg::CHANNELS && i < rsb_pkg::PIN_W; i++) begin
            r.pin_levels[i] = sw_on[i] ^ cfg_byte[i][rsb_pkg::CFG_POLARITY_BIT];
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_bank
        rsb_pkg::t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < rsb_pkg::CHANNELS; i++) begin
                sw_on[i]     = 1'b0;
                cfg_byte[i]  = '0;
                dly_limit[i] = '0;
                dly_count[i] = '0;
            end
            expected_replies.delete();
        end else begin
            // Results lag their command, so compare before taking a new one.
            if (i_strobe) begin
                if (expected_replies.size() == 0) begin
                    $error("result with no command waiting: 0x%0h", i_result);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    compare_field("reply_count", 8'(want.reply_count),
                                  8'(i_result.reply_count));
                    compare_field("reply_high", want.reply_high, i_result.reply_high);
                    compare_field("reply_low", want.reply_low, i_result.reply_low);
                    compare_field("pin_levels", 8'(want.pin_levels),
                                  8'(i_result.pin_levels));
                end
            end
            if (i_start && !i_busy) begin
                expected_replies.push_back(predict_reply(i_cmd));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_replies.size();
    end

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench top that drives commands into the relay switch bank and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 2;
    localparam int RANDOM_ITEMS = 1125;
    localparam int CALM_FIRST   = 300;   // random items without idling: [CALM_FIRST, CALM_LAST)
    localparam int CALM_LAST    = 500;
    localparam int DRAIN_AT     = 700;   // random item before which the sender drains
    localparam int IDLE_PCT     = 37;
    localparam int SETTLE       = 6;     // wait after the final drain before the verdict
    localparam int CYCLE_LIMIT  = 100000;

    logic          clk   = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    rsb_pkg::t_in  command = '0;
    logic          busy;
    logic          strobe;
    rsb_pkg::t_out result;
    int            fail_count;
    int            pending;
    int            cycle_count = 0;
    bit            idle_enable = 1'b1;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    relay_switch_bank_with_off_delay_top i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_cmd    (command),
        .o_strobe (strobe),
        .o_result (result)
    );

    rsb_bank_checker u_bank_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (command),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic rsb_pkg::t_in make_cmd(input rsb_pkg::t_action a,
                                              input logic [1:0] ch,
                                              input logic [7:0] addr, input logic [3:0] len,
                                              input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
        rsb_pkg::t_in c;
        c.action  = a;
        c.channel = ch;
        c.address = addr;
        c.length  = len;
        c.byte0   = b0;
        c.byte1   = b1;
        c.byte2   = b2;
        return c;
    endfunction

    // Mostly well-formed register traffic with short delays, so that ticks
    // really switch channels off; the rest is odd addresses and lengths.
    function automatic rsb_pkg::t_in random_cmd();
        rsb_pkg::t_in c;
        int           pick;
        c.channel = 2'($urandom_range(3));
        c.byte0   = 8'($urandom_range(255));
        c.byte1   = 8'($urandom_range(255));
        c.byte2   = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 30) begin
            c.action = rsb_pkg::ACT_READ;
        end else if (pick < 65) begin
            c.action = rsb_pkg::ACT_WRITE;
        end else if (pick < 88) begin
            c.action = rsb_pkg::ACT_TICK;
        end else begin
            c.action = rsb_pkg::ACT_RESTORE;
        end
        if ($urandom_range(99) < 88) begin
            c.address = 8'($urandom_range(2));
        end else begin
            c.address = 8'($urandom_range(255));
        end
        if ($urandom_range(99) < 80) begin
            c.length = (c.address == rsb_pkg::ADDR_DELAY) ? rsb_pkg::LEN_DELAY
                                                          : rsb_pkg::LEN_CONFIG;
        end else begin
            c.length = 4'($urandom_range(15));
        end
        if (c.action == rsb_pkg::ACT_WRITE && c.address == rsb_pkg::ADDR_VALUE
                && $urandom_range(1) == 0) begin
            c.byte0 = 8'd0;
        end
        if ($urandom_range(99) < 75) begin
            if (c.action == rsb_pkg::ACT_WRITE && c.address == rsb_pkg::ADDR_DELAY) begin
                c.byte0 = 8'd0;
                c.byte1 = 8'($urandom_range(6));
            end else if (c.action == rsb_pkg::ACT_RESTORE) begin
                c.byte1 = 8'd0;
                c.byte2 = 8'($urandom_range(6));
            end
        end
        return c;
    endfunction

    // Present one command and hold it until the bank takes the transfer.
    task automatic send(input rsb_pkg::t_in c);
        // Idle with junk on the command bus; the bank must ignore it.
        while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
            start   <= 1'b0;
            command <= random_cmd();
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= c;
        do @(posedge clk); while (busy);
    endtask

    // Stop sending and hold until every outstanding result is back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Watchdog: end the run if the bank stops answering.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        // Hold reset over the first edges, then release it once.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: reset values, register extremes and the special cases.
        send(make_cmd(rsb_pkg::ACT_READ, 2'd0, rsb_pkg::ADDR_CONFIG, 4'd0,
                      8'h00, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_READ, 2'd1, rsb_pkg::ADDR_VALUE, 4'd15,
                      8'hff, 8'hff, 8'hff));
        send(make_cmd(rsb_pkg::ACT_READ, 2'd3, rsb_pkg::ADDR_DELAY, 4'd0,
                      8'h00, 8'h00, 8'h00));
        // unknown address: a result with no reply bytes
        send(make_cmd(rsb_pkg::ACT_READ, 2'd2, 8'hff, 4'd1, 8'h00, 8'h00, 8'h00));
        // config write keeps only the three defined bits
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd0, rsb_pkg::ADDR_CONFIG, rsb_pkg::LEN_CONFIG,
                      8'hff, 8'h00, 8'h00));
        // wrong lengths: dropped
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd1, rsb_pkg::ADDR_CONFIG, 4'd0,
                      8'h07, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd1, rsb_pkg::ADDR_CONFIG, 4'd15,
                      8'h07, 8'h00, 8'h00));
        // any nonzero value turns the switch on
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd0, rsb_pkg::ADDR_VALUE, rsb_pkg::LEN_VALUE,
                      8'h80, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd0, rsb_pkg::ADDR_DELAY, rsb_pkg::LEN_DELAY,
                      8'hff, 8'hff, 8'h00));
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd0, rsb_pkg::ADDR_DELAY, 4'd1,
                      8'h00, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_READ, 2'd0, rsb_pkg::ADDR_DELAY, 4'd0,
                      8'h00, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd2, rsb_pkg::ADDR_VALUE, rsb_pkg::LEN_VALUE,
                      8'hff, 8'h00, 8'h00));
        // restore stores the config unmasked, zero delay, default on
        send(make_cmd(rsb_pkg::ACT_RESTORE, 2'd3, 8'h00, 4'd0, 8'hff, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_READ, 2'd3, rsb_pkg::ADDR_CONFIG, 4'd0,
                      8'h00, 8'h00, 8'h00));
        // zero delay switches off on the first tick
        send(make_cmd(rsb_pkg::ACT_TICK, 2'd0, 8'h00, 4'd0, 8'h00, 8'h00, 8'h00));
        // shrink the delay down to the running timer value
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd0, rsb_pkg::ADDR_DELAY, rsb_pkg::LEN_DELAY,
                      8'h00, 8'h01, 8'h00));
        send(make_cmd(rsb_pkg::ACT_TICK, 2'd3, 8'hff, 4'd15, 8'hff, 8'hff, 8'hff));
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd1, 8'hff, rsb_pkg::LEN_VALUE,
                      8'h01, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd1, 8'h03, rsb_pkg::LEN_DELAY,
                      8'h01, 8'h01, 8'h00));
        send(make_cmd(rsb_pkg::ACT_RESTORE, 2'd1, 8'hff, 4'd15, 8'h00, 8'hff, 8'hff));
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd1, rsb_pkg::ADDR_VALUE, rsb_pkg::LEN_VALUE,
                      8'h01, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_TICK, 2'd0, 8'h00, 4'd0, 8'h00, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_READ, 2'd1, rsb_pkg::ADDR_VALUE, 4'd0,
                      8'h00, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_WRITE, 2'd1, rsb_pkg::ADDR_VALUE, rsb_pkg::LEN_VALUE,
                      8'h00, 8'h00, 8'h00));
        send(make_cmd(rsb_pkg::ACT_READ, 2'd2, rsb_pkg::ADDR_VALUE, 4'd0,
                      8'h00, 8'h00, 8'h00));
        drain();

        // Random part, with a calm stretch and one more full drain.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_enable = !(n >= CALM_FIRST && n < CALM_LAST);
            if (n == DRAIN_AT) begin
                drain();
            end
            send(random_cmd());
        end

        // Wait out the last results, then give the verdict.
        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
